// ===== design/plc_pkg.sv =====
`default_nettype none

package plc_pkg;

  // Sample and table geometry.
  localparam int SW        = 24;
  localparam int TAB_BITS  = 8;
  localparam int TAB_N     = 1 << TAB_BITS;

  // Gain register: unsigned Q8.8, reset to 8.0.
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 8;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(8 << GAIN_FRAC);

  // Logarithms are carried in Q.24; the log table holds values up to 1.0.
  localparam int FRAC_W    = 24;
  localparam int LOG_W     = FRAC_W + 1;
  // Exp table holds values in Q.30 up to 2.0.
  localparam int EXP_W     = 32;

  // The log2 input width covers both the sample magnitude and the gain.
  localparam int LOG_IN_W  = (SW > GAIN_W) ? SW : GAIN_W;
  localparam int LPOS_W    = $clog2(LOG_IN_W);
  localparam int NORM_W    = 32;
  localparam int LRB_W     = NORM_W - 1 - TAB_BITS;
  localparam int ERB_W     = FRAC_W - TAB_BITS;

  // Exponent arithmetic widths.
  localparam int LA_W      = FRAC_W + $clog2(SW);
  localparam int LGM_W     = FRAC_W + $clog2(GAIN_FRAC) + 1;
  localparam int P1_W      = LGM_W + LA_W - FRAC_W;
  localparam int L10_W     = 31;
  localparam logic [L10_W-1:0] LOG10_2_Q32 = L10_W'(1292913986);
  localparam int P2_W      = P1_W + L10_W;
  localparam int UE_W      = FRAC_W + 8;
  localparam int HI_W      = UE_W - FRAC_W;
  localparam logic [UE_W-1:0] EXP_BIAS = UE_W'(128) << FRAC_W;
  // Integer part of the biased exponent at which the mantissa needs no shift.
  localparam int EXP_SAT_HI = 128 + 31 - SW;

  // Result magnitude and full-scale limits.
  localparam int MAG_W     = EXP_W + 1;
  localparam logic [MAG_W-1:0] MAG_POS_MAX = MAG_W'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic [MAG_W-1:0] MAG_NEG_MAX = MAG_W'(64'd1 << (SW - 1));
  localparam logic [SW-1:0] OUT_POS_MAX = SW'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic [SW-1:0] OUT_NEG_MIN = SW'(64'd1 << (SW - 1));

  // Pipeline latencies of the units and of the whole datapath.
  localparam int LOG_LAT    = 5;
  localparam int EXP_LAT    = 5;
  localparam int PIPE_DEPTH = LOG_LAT + 3 + EXP_LAT + 1;

  // Result of the log2 unit: leading-one position and fraction in Q.24.
  typedef struct packed {
    logic [LPOS_W-1:0] pos;
    logic [LOG_W-1:0]  frac;
  } log_res_t;

  // Operand of the exp2 unit: exponent magnitude and its direction.
  typedef struct packed {
    logic            up;
    logic [UE_W-1:0] em;
  } exp_arg_t;

  // Result of the exp2 unit: scaled magnitude, or a flag for far above full scale.
  typedef struct packed {
    logic             big;
    logic [MAG_W-1:0] mag;
  } exp_res_t;

  // Floor integer square root, bit by bit.
  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x   = val;
    res = '0;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > x) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (x >= res + b) begin
          x   = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // Root 2^(2^-j) in Q.30, by repeated square roots of 2.0.
  function automatic logic [63:0] root_q30(input int j);
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int k = 1; k <= j; k++) begin
      r = isqrt64(r << 30);
    end
    return r;
  endfunction

  // Log table entry: log2(1 + i/N) in Q.24, by repeated squaring in Q.30.
  function automatic logic [LOG_W-1:0] log_entry(input int i);
    logic [63:0] x;
    logic [63:0] r;
    x = (64'd1 << 30) + (64'(i) << (30 - TAB_BITS));
    r = '0;
    for (int k = 1; k <= FRAC_W; k++) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        r = r | (64'd1 << (FRAC_W - k));
      end
    end
    if (i == TAB_N) r = 64'd1 << FRAC_W;
    return r[LOG_W-1:0];
  endfunction

  // Exp table entry: 2^(i/N) in Q.30, as a product of truncated roots.
  function automatic logic [EXP_W-1:0] exp_entry(input int i);
    logic [63:0] y;
    y = 64'd1 << 30;
    for (int k = 0; k < TAB_BITS; k++) begin
      if (((i >> k) & 1) != 0) y = (y * root_q30(TAB_BITS - k)) >> 30;
    end
    if (i == TAB_N) y = 64'd1 << 31;
    return y[EXP_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/plc_log2.sv =====
`default_nettype none

module plc_log2 (
  input  logic                          clk,
  input  logic [plc_pkg::LOG_IN_W-1:0]  mag_in,
  output plc_pkg::log_res_t             res
);
  import plc_pkg::*;

  localparam int NSH_W = $clog2(NORM_W);

  // Constant log2 table with one extra entry for interpolation at the top.
  logic [LOG_W-1:0] log_rom [TAB_N+1];
  for (genvar i = 0; i <= TAB_N; i++) begin : g_rom
    localparam logic [LOG_W-1:0] ENTRY = log_entry(i);
    assign log_rom[i] = ENTRY;
  end

  logic [LPOS_W-1:0]   pos_c;
  logic [NORM_W-1:0]   norm_c;

  logic [LOG_IN_W-1:0] mag1;
  logic [LPOS_W-1:0]   pos1, pos2, pos3, pos4;
  logic [TAB_BITS-1:0] idx2;
  logic [LRB_W-1:0]    rem2, rem3;
  logic [LOG_W-1:0]    a3, d3, a4, prod4;
  logic [LOG_W-1:0]    lo_c, hi_c;

  // Leading-one position of the magnitude.
  always_comb begin
    pos_c = '0;
    for (int i = 0; i < LOG_IN_W; i++) begin
      if (mag_in[i]) pos_c = LPOS_W'(i);
    end
  end

  // Normalize so that the leading one sits at the top of the word.
  assign norm_c = NORM_W'(mag1) << (NSH_W'(NORM_W - 1) - NSH_W'(pos1));

  // Table neighbors around the index.
  assign lo_c = log_rom[{1'b0, idx2}];
  assign hi_c = log_rom[{1'b0, idx2} + (TAB_BITS + 1)'(1)];

  always_ff @(posedge clk) begin
    // Stage 1: leading-one detect.
    mag1  <= mag_in;
    pos1  <= pos_c;
    // Stage 2: split the bits below the leading one into index and remainder.
    pos2  <= pos1;
    idx2  <= norm_c[NORM_W-2 -: TAB_BITS];
    rem2  <= norm_c[LRB_W-1:0];
    // Stage 3: table lookup and slope.
    pos3  <= pos2;
    rem3  <= rem2;
    a3    <= lo_c;
    d3    <= (hi_c > lo_c) ? (hi_c - lo_c) : '0;
    // Stage 4: slope times remainder, truncated.
    pos4  <= pos3;
    a4    <= a3;
    prod4 <= LOG_W'(((LOG_W + LRB_W)'(d3) * (LOG_W + LRB_W)'(rem3)) >> LRB_W);
    // Stage 5: interpolated fraction.
    res.pos  <= pos4;
    res.frac <= a4 + prod4;
  end

endmodule

`default_nettype wire

// ===== design/plc_exp2.sv =====
`default_nettype none

module plc_exp2 (
  input  logic              clk,
  input  plc_pkg::exp_arg_t arg,
  output plc_pkg::exp_res_t res
);
  import plc_pkg::*;

  localparam int RSH_W = $clog2(EXP_W);

  // Constant exp2 table with one extra entry for interpolation at the top.
  logic [EXP_W-1:0] exp_rom [TAB_N+1];
  for (genvar i = 0; i <= TAB_N; i++) begin : g_rom
    localparam logic [EXP_W-1:0] ENTRY = exp_entry(i);
    assign exp_rom[i] = ENTRY;
  end

  logic [UE_W-1:0]     ue_c;
  logic [HI_W-1:0]     hi1, hi2, hi3, hi4;
  logic [TAB_BITS-1:0] idx1;
  logic [ERB_W-1:0]    rem1, rem2;
  logic [EXP_W-1:0]    a2, d2, a3, prod3, mant4;
  logic [EXP_W-1:0]    lo_c, hi_c;
  logic [HI_W-1:0]     rsh_c;
  logic [RSH_W-1:0]    sh_c;
  logic                big_next;
  logic [MAG_W-1:0]    mag_next;

  // Biased exponent: the bias keeps it nonnegative.
  assign ue_c = arg.up ? (EXP_BIAS + arg.em) : (EXP_BIAS - arg.em);

  assign lo_c = exp_rom[{1'b0, idx1}];
  assign hi_c = exp_rom[{1'b0, idx1} + (TAB_BITS + 1)'(1)];

  // Scale the mantissa to the output format; right shifts round half up.
  assign rsh_c = HI_W'(EXP_SAT_HI) - hi4;
  assign sh_c  = rsh_c[RSH_W-1:0];

  always_comb begin
    big_next = 1'b0;
    mag_next = '0;
    priority if (hi4 > HI_W'(EXP_SAT_HI + 1)) begin
      big_next = 1'b1;
    end else if (hi4 == HI_W'(EXP_SAT_HI + 1)) begin
      mag_next = {mant4, 1'b0};
    end else if (hi4 == HI_W'(EXP_SAT_HI)) begin
      mag_next = {1'b0, mant4};
    end else if (rsh_c >= HI_W'(EXP_W)) begin
      mag_next = '0;
    end else begin
      mag_next = (MAG_W'(mant4) + (MAG_W'(1) << (sh_c - RSH_W'(1)))) >> sh_c;
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1: integer part, table index and remainder.
    hi1   <= ue_c[UE_W-1 -: HI_W];
    idx1  <= ue_c[FRAC_W-1 -: TAB_BITS];
    rem1  <= ue_c[ERB_W-1:0];
    // Stage 2: table lookup and slope.
    hi2   <= hi1;
    rem2  <= rem1;
    a2    <= lo_c;
    d2    <= (hi_c > lo_c) ? (hi_c - lo_c) : '0;
    // Stage 3: slope times remainder, truncated.
    hi3   <= hi2;
    a3    <= a2;
    prod3 <= EXP_W'(((EXP_W + ERB_W)'(d2) * (EXP_W + ERB_W)'(rem2)) >> ERB_W);
    // Stage 4: interpolated mantissa in Q.30.
    hi4   <= hi3;
    mant4 <= a3 + prod3;
    // Stage 5: shifted magnitude.
    res.big <= big_next;
    res.mag <= mag_next;
  end

endmodule

`default_nettype wire

// ===== design/power_law_sample_compander_top.sv =====
`default_nettype none

// Channel   Dir  Handshake            Beat contents
// sample    in   start high, busy low sample_in, last_in
// result    out  done strobe, 1 cycle sample_out, saturated, last_out
// config    in   cfg_we               cfg_data (gain, unsigned Q8.8)
//
// One sample is taken every clock outside reset; done rises once the beat has
// passed the input register, the 5-stage log2 units, 3 stages for the exponent
// products, the 5-stage exp2 unit and the output register.
// Synchronous reset empties the pipeline and sets gain to 8.0; busy is high only
// during reset. Results cannot be held off, so the pipeline never stalls.

module power_law_sample_compander_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [plc_pkg::SW-1:0]        sample_in,
  input  logic                                 last_in,
  input  logic                                 cfg_we,
  input  logic        [plc_pkg::GAIN_W-1:0]    cfg_data,
  output logic                                 done,
  output logic signed [plc_pkg::SW-1:0]        sample_out,
  output logic                                 saturated,
  output logic                                 last_out
);
  import plc_pkg::*;

  typedef struct packed {
    logic neg;
    logic zero;
    logic last;
  } side_t;

  logic [GAIN_W-1:0]   gain;
  logic [PIPE_DEPTH:0] vld;
  side_t               side_q [PIPE_DEPTH];
  logic [SW-1:0]       smp_u;
  logic [SW-1:0]       abs_c;
  logic [LOG_IN_W-1:0] mag0, gmag0;
  log_res_t            lres, gres;
  logic [LA_W-1:0]     la1;
  logic [LGM_W-1:0]    lgm1;
  logic                up1, up2, up3;
  logic [P1_W-1:0]     p12;
  logic [UE_W-1:0]     em3;
  exp_arg_t            earg;
  exp_res_t            eres;
  side_t               side_f;
  logic [SW-1:0]       res_next;
  logic                sat_next;

  assign busy = rst;

  // Gain register.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_we) begin
      gain <= cfg_data;
    end
  end

  // Valid bits travel down the pipeline with each beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-1:0], start && !busy};
    end
  end

  // Input stage: magnitude of the sample and the gain operand.
  assign smp_u = sample_in;
  assign abs_c = smp_u[SW-1] ? (SW'(0) - smp_u) : smp_u;

  always_ff @(posedge clk) begin
    mag0      <= LOG_IN_W'(abs_c);
    gmag0     <= (gain == '0) ? LOG_IN_W'(1) : LOG_IN_W'(gain);
    side_q[0] <= '{neg: smp_u[SW-1], zero: (smp_u == '0), last: last_in};
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // Log2 of the sample magnitude and of the gain, side by side.
  plc_log2 u_log_smp (
    .clk    (clk),
    .mag_in (mag0),
    .res    (lres)
  );

  plc_log2 u_log_gain (
    .clk    (clk),
    .mag_in (gmag0),
    .res    (gres)
  );

  // Exponent: log2(gain) * (SW-1 - log2|x|) * log10(2), in three stages.
  always_ff @(posedge clk) begin
    la1 <= ((LA_W'(SW - 1) - LA_W'(lres.pos)) << FRAC_W) - LA_W'(lres.frac);
    up1 <= (gres.pos < LPOS_W'(GAIN_FRAC));
    if (gres.pos < LPOS_W'(GAIN_FRAC)) begin
      lgm1 <= (LGM_W'(LPOS_W'(GAIN_FRAC) - gres.pos) << FRAC_W) - LGM_W'(gres.frac);
    end else begin
      lgm1 <= (LGM_W'(gres.pos - LPOS_W'(GAIN_FRAC)) << FRAC_W) + LGM_W'(gres.frac);
    end
    up2 <= up1;
    p12 <= P1_W'(((LGM_W + LA_W)'(lgm1) * (LGM_W + LA_W)'(la1)) >> FRAC_W);
    up3 <= up2;
    em3 <= UE_W'((P2_W'(p12) * P2_W'(LOG10_2_Q32)) >> 32);
  end

  assign earg = '{up: up3, em: em3};

  plc_exp2 u_exp (
    .clk (clk),
    .arg (earg),
    .res (eres)
  );

  // Output stage: saturate to full scale and restore the sign.
  assign side_f = side_q[PIPE_DEPTH-1];

  always_comb begin
    res_next = '0;
    sat_next = 1'b0;
    if (side_f.zero) begin
      res_next = '0;
    end else if (side_f.neg) begin
      if (eres.big || (eres.mag > MAG_NEG_MAX)) begin
        res_next = OUT_NEG_MIN;
        sat_next = 1'b1;
      end else begin
        res_next = SW'(0) - eres.mag[SW-1:0];
      end
    end else begin
      if (eres.big || (eres.mag > MAG_POS_MAX)) begin
        res_next = OUT_POS_MAX;
        sat_next = 1'b1;
      end else begin
        res_next = eres.mag[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    sample_out <= res_next;
    saturated  <= sat_next;
    last_out   <= side_f.last;
  end

  assign done = vld[PIPE_DEPTH];

  // Every accepted beat comes out after the full pipeline depth.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(PIPE_DEPTH + 1) done)
    else $error("accepted sample did not come out on time");

  // A clipped result sits exactly at one of the full-scale limits.
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (sample_out == OUT_POS_MAX || sample_out == OUT_NEG_MIN))
    else $error("saturated result is not at full scale");

  // Reset leaves the pipeline empty.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result strobe right after reset");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import plc_pkg::*;

  // log10(2) in Q.32, used to turn log2 products into log10 exponents.
  localparam longint unsigned LOG10_TWO = 64'd1292913986;
  localparam int LOG_RBITS = 31 - TAB_BITS;
  localparam int EXP_RBITS = 24 - TAB_BITS;
  localparam int N_PHASES = 10;
  localparam int PHASE_BEATS = 160;

  typedef struct packed {
    logic [SW-1:0] smp;
    logic          sat;
    logic          lst;
  } comp_beat_t;

  // Tracks the gain register, predicts each companded sample and checks results.
  class compander_scoreboard;
    longint unsigned gain_q8;
    longint unsigned log_tab[TAB_N+1];
    longint unsigned exp_tab[TAB_N+1];
    comp_beat_t      expected_q[$];
    int              errors;

    function new();
      gain_q8 = 64'(GAIN_RESET);
      errors  = 0;
      build_tables();
    endfunction

    // Floor square root, found one result bit at a time from the top.
    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= x) r = t;
      end
      return r;
    endfunction

    // Log2 table by repeated squaring, exp2 table as products of truncated roots.
    function void build_tables();
      longint unsigned root[TAB_BITS+1];
      longint unsigned x;
      longint unsigned r;
      longint unsigned y;
      root[0] = 64'd1 << 31;
      for (int k = 1; k <= TAB_BITS; k++) root[k] = int_sqrt(root[k-1] << 30);
      for (int i = 0; i <= TAB_N; i++) begin
        if (i == TAB_N) begin
          log_tab[i] = 64'd1 << 24;
          exp_tab[i] = 64'd1 << 31;
        end else begin
          x = (64'd1 << 30) + (64'(i) << (30 - TAB_BITS));
          r = 0;
          for (int k = 1; k <= 24; k++) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
              x = x >> 1;
              r = r | (64'd1 << (24 - k));
            end
          end
          log_tab[i] = r;
          y = 64'd1 << 30;
          for (int k = 0; k < TAB_BITS; k++) begin
            if (((i >> k) & 1) != 0) y = (y * root[TAB_BITS-k]) >> 30;
          end
          exp_tab[i] = y;
        end
      end
    endfunction

    // Linear interpolation between two neighboring entries, truncated.
    function longint unsigned lerp(longint unsigned lo, longint unsigned hi,
                                   longint unsigned rem, int rbits);
      longint unsigned d;
      d = (hi > lo) ? hi - lo : 0;
      return lo + ((d * rem) >> rbits);
    endfunction

    // Fractional log2 in Q.24; pos receives the leading-one position.
    function longint unsigned log2_q24(longint unsigned m, output int pos);
      int              p;
      longint unsigned frac;
      longint unsigned idx;
      p = 0;
      while (p < 31 && (m >> (p + 1)) != 0) p++;
      pos  = p;
      frac = ((m << (31 - p)) & 64'hFFFF_FFFF) - (64'd1 << 31);
      idx  = (frac >> LOG_RBITS) & (TAB_N - 1);
      return lerp(log_tab[idx], log_tab[idx+1], frac & ((64'd1 << LOG_RBITS) - 1),
                  LOG_RBITS);
    endfunction

    // Expected result for one sample under the current gain.
    function comp_beat_t companded(logic [SW-1:0] sample, logic lst);
      comp_beat_t      beat;
      longint unsigned wmask, half, v, m, lf, la, g, lgf, lgm, em, ue, f, idx;
      longint unsigned mant, mag, res;
      longint          lg, n, shift;
      int              p, pg;
      logic            neg, sat;
      wmask = (64'd1 << SW) - 1;
      half  = 64'd1 << (SW - 1);
      v     = 64'(sample);
      res   = 0;
      sat   = 1'b0;
      if (v != 0) begin
        neg = v[SW-1];
        m   = neg ? ((wmask - v + 1) & wmask) : v;
        if (neg && m == 0) m = half;
        lf  = log2_q24(m, p);
        la  = (64'(SW - 1 - p) << 24) - lf;
        g   = gain_q8 & 64'hFFFF;
        if (g == 0) g = 1;
        lgf = log2_q24(g, pg);
        lg  = longint'(pg - 8) * (longint'(1) << 24) + longint'(lgf);
        lgm = (lg < 0) ? 64'(-lg) : 64'(lg);
        em  = (((lgm * la) >> 24) * LOG10_TWO) >> 32;
        // Bias keeps the exponent nonnegative; gain above 1.0 pulls it down.
        ue  = (lg < 0) ? ((64'd128 << 24) + em) : ((64'd128 << 24) - em);
        n   = longint'(ue >> 24) - 128;
        f   = ue & ((64'd1 << 24) - 1);
        idx = (f >> EXP_RBITS) & (TAB_N - 1);
        mant = lerp(exp_tab[idx], exp_tab[idx+1], f & ((64'd1 << EXP_RBITS) - 1),
                    EXP_RBITS);
        shift = n + SW - 1 - 30;
        if (shift >= 33) begin
          mag = 64'd1 << 63;
        end else if (shift >= 0) begin
          mag = mant << shift;
        end else if (shift <= -40) begin
          mag = 0;
        end else begin
          mag = (mant + (64'd1 << (-shift - 1))) >> (-shift);
        end
        // Clip to full scale in the direction of the sign.
        if (neg) begin
          if (mag > half) begin
            mag = half;
            sat = 1'b1;
          end
          res = (64'd0 - mag) & wmask;
        end else begin
          if (mag > half - 1) begin
            mag = half - 1;
            sat = 1'b1;
          end
          res = mag & wmask;
        end
      end
      beat.smp = res[SW-1:0];
      beat.sat = sat;
      beat.lst = lst;
      return beat;
    endfunction

    function void note_sample(logic [SW-1:0] sample, logic lst);
      expected_q.push_back(companded(sample, lst));
    endfunction

    function void check_result(logic [SW-1:0] smp, logic sat, logic lst);
      comp_beat_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no sample pending: sample_out %0d", $signed(smp));
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (want.smp !== smp) begin
        $error("sample_out: expected %0d, actual %0d", $signed(want.smp), $signed(smp));
        errors++;
      end
      if (want.sat !== sat) begin
        $error("saturated: expected %0b, actual %0b", want.sat, sat);
        errors++;
      end
      if (want.lst !== lst) begin
        $error("last_out: expected %0b, actual %0b", want.lst, lst);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic signed [SW-1:0]  sample_in;
  logic                  last_in;
  logic                  cfg_we;
  logic [GAIN_W-1:0]     cfg_data;
  logic                  done;
  logic signed [SW-1:0]  sample_out;
  logic                  saturated;
  logic                  last_out;
  bit                    no_idle;
  compander_scoreboard   sb;

  power_law_sample_compander_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .sample_in  (sample_in),
    .last_in    (last_in),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .done       (done),
    .sample_out (sample_out),
    .saturated  (saturated),
    .last_out   (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sample every handshake at the rising edge: gain writes, input beats, results.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.gain_q8 = 64'(cfg_data);
      if (start && !busy) sb.note_sample(sample_in, last_in);
      if (done) sb.check_result(sample_out, saturated, last_out);
    end
  end

  // Idle cycles before a beat: mostly none or a few, now and then a long pause.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mix of corner values, full-width noise and magnitudes of every bit length.
  function automatic logic [SW-1:0] random_sample();
    int            sel;
    int            len;
    logic [SW-1:0] v;
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      case ($urandom_range(0, 4))
        0: v = '0;
        1: v = SW'(1);
        2: v = '1;
        3: v = OUT_POS_MAX;
        default: v = OUT_NEG_MIN;
      endcase
    end else if (sel < 5) begin
      v = SW'($urandom);
    end else begin
      len = $urandom_range(1, SW - 1);
      v = SW'($urandom) & ((SW'(1) << len) - SW'(1));
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input logic [SW-1:0] smp, input logic lst);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     = 1'b1;
    sample_in = smp;
    last_in   = lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // The gain changes only with the pipeline empty.
  task automatic write_gain(input logic [GAIN_W-1:0] g);
    start = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = g;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  initial begin
    logic [SW-1:0]     corner[$];
    logic [GAIN_W-1:0] gain_plan[$];
    rst       = 1'b1;
    start     = 1'b0;
    sample_in = '0;
    last_in   = 1'b0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    no_idle   = 1'b0;
    sb        = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Corner samples under the reset gain of 8.0.
    corner = '{SW'(0), SW'(1), SW'(-1), OUT_POS_MAX, OUT_NEG_MIN, SW'(2), SW'(-2),
               SW'(4194304), SW'(-4194304), SW'(-8388607), SW'(255), SW'(256),
               SW'(5592405), SW'(-2796203), SW'(65535), SW'(7)};
    foreach (corner[i]) send_beat(corner[i], 1'(i % 3 == 2));

    // Gain 1.0 saturates positive samples; below 1.0 the result grows past full scale.
    gain_plan = '{GAIN_W'(256), GAIN_W'(0), GAIN_W'(1), GAIN_W'(128), '1,
                  GAIN_W'(255), GAIN_W'(257), GAIN_W'(2560),
                  GAIN_W'($urandom), GAIN_RESET};
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_gain(gain_plan[ph]);
      no_idle = (ph % 3 == 2);
      repeat (PHASE_BEATS) send_beat(random_sample(), 1'($urandom_range(0, 7) == 0));
    end
    start   = 1'b0;
    no_idle = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/plc_pkg.sv
design/plc_log2.sv
design/plc_exp2.sv
design/power_law_sample_compander_top.sv
dv/tb.sv
